// ===== hw/rtl/convex_hull_2d_core_defines.svh =====
// ----------------------------------------------------------------------------
// convex hull core assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef CONVEX_HULL_2D_CORE_DEFINES_SVH
`define CONVEX_HULL_2D_CORE_DEFINES_SVH

// property holds at every edge outside reset
`define CH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/chull_pkg.sv =====
// ----------------------------------------------------------------------------
// chull_pkg
// shared constants and controller/datapath command and status types
// ----------------------------------------------------------------------------
package chull_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int COORD_BITS_DEF = 16;
    localparam int COUNT_BITS     = 6;
    // command address width, covers the largest store depth
    localparam int CMD_AW         = 8;

    // index memory write data select
    localparam logic [2:0] WS_VAL = 3'd0;
    localparam logic [2:0] WS_T   = 3'd1;
    localparam logic [2:0] WS_P   = 3'd2;
    localparam logic [2:0] WS_VI  = 3'd3;
    localparam logic [2:0] WS_RD  = 3'd4;

    typedef struct packed {
        logic [CMD_AW-1:0]     idx_raddr;
        logic                  idx_we;
        logic [CMD_AW-1:0]     idx_waddr;
        logic [2:0]            idx_wsel;
        logic [CMD_AW-1:0]     idx_wval;
        logic                  crd_we;
        logic [CMD_AW-1:0]     crd_waddr;
        logic                  ld_t;
        logic                  ld_p;
        logic                  ld_vi;
        logic                  ld_tc;
        logic                  ld_ic;
        logic                  ld_jc;
        logic                  ld_kc;
        logic                  ld_diff;
        logic                  ld_prod;
        logic                  ld_out;
        logic                  rev;
        logic [COUNT_BITS-1:0] out_count;
        logic                  out_final;
        logic                  out_ovf;
    } t_cmd;

    typedef struct packed {
        logic lt;
        logic right;
    } t_sts;

endpackage

// ===== hw/rtl/chull_pt_if.sv =====
// ----------------------------------------------------------------------------
// chull_pt_if
// point input channel: valid/ready with coordinates and last flag
// ----------------------------------------------------------------------------
interface chull_pt_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         last;

    modport source (output valid, output x, output y, output last, input ready);
    modport sink   (input valid, input x, input y, input last, output ready);
endinterface

// ===== hw/rtl/chull_hull_if.sv =====
// ----------------------------------------------------------------------------
// chull_hull_if
// hull vertex output channel: valid/ready with vertex and run info
// ----------------------------------------------------------------------------
interface chull_hull_if #(
    parameter int COORD_BITS = 16
);
    import chull_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] hull_x;
    logic signed [COORD_BITS-1:0] hull_y;
    logic [COUNT_BITS-1:0]        hull_count;
    logic                         final_vertex;
    logic                         overflow;

    modport source (output valid, output hull_x, output hull_y, output hull_count,
                    output final_vertex, output overflow, input ready);
    modport sink   (input valid, input hull_x, input hull_y, input hull_count,
                    input final_vertex, input overflow, output ready);
endinterface

// ===== hw/rtl/convex_hull_2d_core.sv =====
// load: n points load one beat per cycle; after the last beat the insertion sort runs over
//   each element with its shifts, then the chain build runs step by step with its pops
// a new point set is not accepted until the last hull vertex of the set before is taken
// output: one hull vertex beat at a time, each held until ready
// reset: synchronous active low clears control and point count; memories keep contents
// ----------------------------------------------------------------------------
// convex_hull_2d_core
// planar convex hull by monotone chain over a stored point set
// ----------------------------------------------------------------------------
module convex_hull_2d_core #(
    parameter int MAX_POINTS = chull_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chull_pkg::COORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    chull_pt_if.sink     i_pt,
    chull_hull_if.source o_hull
);
    import chull_pkg::*;

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: point count, loop indexes and the handshakes
    chull_ctrl #(
        .MAX_POINTS(MAX_POINTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pt.valid),
        .i_in_last  (i_pt.last),
        .o_in_ready (i_pt.ready),
        .o_out_valid(o_hull.valid),
        .i_out_ready(o_hull.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // datapath: point store, index permutation, compare and cross product
    chull_datapath #(
        .MAX_POINTS(MAX_POINTS),
        .COORD_BITS(COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_x           (i_pt.x),
        .i_y           (i_pt.y),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_hull_x      (o_hull.hull_x),
        .o_hull_y      (o_hull.hull_y),
        .o_hull_count  (o_hull.hull_count),
        .o_final_vertex(o_hull.final_vertex),
        .o_overflow    (o_hull.overflow)
    );
endmodule

// ===== hw/rtl/chull_datapath.sv =====
// ----------------------------------------------------------------------------
// chull_datapath
// point and index memories, sort compare, cross product and output register
// ----------------------------------------------------------------------------
module chull_datapath #(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                             i_clk,
    input  logic signed [COORD_BITS-1:0]     i_x,
    input  logic signed [COORD_BITS-1:0]     i_y,
    input  chull_pkg::t_cmd                  i_cmd,
    output chull_pkg::t_sts                  o_sts,
    output logic signed [COORD_BITS-1:0]     o_hull_x,
    output logic signed [COORD_BITS-1:0]     o_hull_y,
    output logic [chull_pkg::COUNT_BITS-1:0] o_hull_count,
    output logic                             o_final_vertex,
    output logic                             o_overflow
);
    import chull_pkg::*;

    localparam int AW = $clog2(MAX_POINTS + 1);
    localparam int IW = $clog2(MAX_POINTS);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic [IW-1:0]                r_idx_mem [0:MAX_POINTS];
    logic signed [COORD_BITS-1:0] r_xm [0:MAX_POINTS-1];
    logic signed [COORD_BITS-1:0] r_ym [0:MAX_POINTS-1];

    logic [IW-1:0]                r_idx_rd, r_t, r_p, r_vi;
    logic signed [COORD_BITS-1:0] r_cx, r_cy, r_tx, r_ty, r_ix, r_iy;
    logic signed [COORD_BITS-1:0] r_jx, r_jy, r_kx, r_ky;
    logic signed [DW-1:0]         r_a, r_b, r_c, r_d;
    logic signed [PW-1:0]         r_ad, r_bc;
    logic [IW-1:0]                n_wdata;

    always_comb begin
        case (i_cmd.idx_wsel)
            WS_VAL:  n_wdata = i_cmd.idx_wval[IW-1:0];
            WS_T:    n_wdata = r_t;
            WS_P:    n_wdata = r_p;
            WS_VI:   n_wdata = r_vi;
            WS_RD:   n_wdata = r_idx_rd;
            default: n_wdata = r_idx_rd;
        endcase
    end

    // index memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_we) begin
            r_idx_mem[i_cmd.idx_waddr[AW-1:0]] <= n_wdata;
        end
        r_idx_rd <= r_idx_mem[i_cmd.idx_raddr[AW-1:0]];
    end

    // point memory, read address follows the index read data
    always_ff @(posedge i_clk) begin
        if (i_cmd.crd_we) begin
            r_xm[i_cmd.crd_waddr[IW-1:0]] <= i_x;
            r_ym[i_cmd.crd_waddr[IW-1:0]] <= i_y;
        end
        r_cx <= r_xm[r_idx_rd];
        r_cy <= r_ym[r_idx_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_t)  r_t  <= r_idx_rd;
        if (i_cmd.ld_p)  r_p  <= r_idx_rd;
        if (i_cmd.ld_vi) r_vi <= r_idx_rd;
        if (i_cmd.ld_tc) begin
            r_tx <= r_cx;
            r_ty <= r_cy;
        end
        if (i_cmd.ld_ic) begin
            r_ix <= r_cx;
            r_iy <= r_cy;
        end
        if (i_cmd.ld_jc) begin
            r_jx <= r_cx;
            r_jy <= r_cy;
        end
        if (i_cmd.ld_kc) begin
            r_kx <= r_cx;
            r_ky <= r_cy;
        end
        if (i_cmd.ld_diff) begin
            r_a <= DW'(r_ix) - DW'(r_jx);
            r_b <= DW'(r_iy) - DW'(r_jy);
            r_c <= DW'(r_kx) - DW'(r_jx);
            r_d <= DW'(r_ky) - DW'(r_jy);
        end
        if (i_cmd.ld_prod) begin
            r_ad <= PW'(r_a) * PW'(r_d);
            r_bc <= PW'(r_b) * PW'(r_c);
        end
        if (i_cmd.ld_out) begin
            o_hull_x       <= r_cx;
            o_hull_y       <= r_cy;
            o_hull_count   <= i_cmd.out_count;
            o_final_vertex <= i_cmd.out_final;
            o_overflow     <= i_cmd.out_ovf;
        end
    end

    // t before p, or p before t on the reversed pass
    always_comb begin
        if (i_cmd.rev) begin
            o_sts.lt = (r_cx < r_tx) || ((r_cx == r_tx) && (r_cy > r_ty));
        end else begin
            o_sts.lt = (r_tx < r_cx) || ((r_tx == r_cx) && (r_ty > r_cy));
        end
        o_sts.right = (r_ad <= r_bc);
    end
endmodule

// ===== hw/rtl/chull_ctrl.sv =====
// ----------------------------------------------------------------------------
// chull_ctrl
// sequencer for load, insertion sort, chain build and vertex output
// ----------------------------------------------------------------------------
module chull_ctrl #(
    parameter int MAX_POINTS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_last,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output chull_pkg::t_cmd o_cmd,
    input  chull_pkg::t_sts i_sts
);
    import chull_pkg::*;
    `include "convex_hull_2d_core_defines.svh"

    localparam int AW = $clog2(MAX_POINTS + 1);
    localparam int LW = AW + 1;
    localparam int HW = LW + COUNT_BITS;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CS   = 5'd1;
    localparam logic [4:0] S_SI0  = 5'd2;
    localparam logic [4:0] S_SI1  = 5'd3;
    localparam logic [4:0] S_SI2  = 5'd4;
    localparam logic [4:0] S_SI3  = 5'd5;
    localparam logic [4:0] S_SI4  = 5'd6;
    localparam logic [4:0] S_SI5  = 5'd7;
    localparam logic [4:0] S_HS   = 5'd8;
    localparam logic [4:0] S_H0   = 5'd9;
    localparam logic [4:0] S_H1   = 5'd10;
    localparam logic [4:0] S_H2   = 5'd11;
    localparam logic [4:0] S_H3   = 5'd12;
    localparam logic [4:0] S_H4   = 5'd13;
    localparam logic [4:0] S_H5   = 5'd14;
    localparam logic [4:0] S_H6   = 5'd15;
    localparam logic [4:0] S_H7   = 5'd16;
    localparam logic [4:0] S_H8   = 5'd17;
    localparam logic [4:0] S_H9   = 5'd18;
    localparam logic [4:0] S_H10  = 5'd19;
    localparam logic [4:0] S_H11  = 5'd20;
    localparam logic [4:0] S_CE   = 5'd21;
    localparam logic [4:0] S_C0   = 5'd22;
    localparam logic [4:0] S_C1   = 5'd23;
    localparam logic [4:0] S_O0   = 5'd24;
    localparam logic [4:0] S_O1   = 5'd25;
    localparam logic [4:0] S_O2   = 5'd26;
    localparam logic [4:0] S_O3   = 5'd27;

    logic [4:0]    r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic          r_drop, n_drop, r_rev, n_rev, r_ovalid, n_ovalid;
    logic [LW-1:0] r_i, n_i, r_j, n_j, r_s, n_s, r_b, n_b, r_m, n_m;
    logic [LW-1:0] r_u, n_u, r_h, n_h, r_k, n_k;
    logic [HW-1:0] h_ext;
    logic          in_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign h_ext       = HW'(r_h);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_drop   = r_drop;
        n_rev    = r_rev;
        n_ovalid = r_ovalid;
        n_i = r_i; n_j = r_j; n_s = r_s; n_b = r_b; n_m = r_m;
        n_u = r_u; n_h = r_h; n_k = r_k;
        o_cmd           = '0;
        o_cmd.rev       = r_rev;
        o_cmd.out_count = h_ext[COUNT_BITS-1:0];
        o_cmd.out_final = ((r_k + LW'(1)) == r_h);
        o_cmd.out_ovf   = r_drop;
        case (r_state)
            S_IDLE: begin
                // store the point and its identity index
                o_cmd.crd_waddr = CMD_AW'(r_cnt);
                o_cmd.idx_waddr = CMD_AW'(r_cnt);
                o_cmd.idx_wval  = CMD_AW'(r_cnt);
                o_cmd.idx_wsel  = WS_VAL;
                if (in_acc) begin
                    if (LW'(r_cnt) < LW'(MAX_POINTS)) begin
                        o_cmd.crd_we = 1'b1;
                        o_cmd.idx_we = 1'b1;
                        n_cnt        = r_cnt + AW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_in_last) begin
                        n_b     = '0;
                        n_m     = LW'(n_cnt);
                        n_rev   = 1'b0;
                        n_state = S_CS;
                    end
                end
            end
            S_CS: begin
                n_i     = LW'(1);
                n_state = (r_m > LW'(1)) ? S_SI0 : S_HS;
            end
            S_SI0: begin
                o_cmd.idx_raddr = CMD_AW'(r_b + r_i);
                n_j             = r_i;
                n_state         = S_SI1;
            end
            S_SI1: begin
                o_cmd.ld_t      = 1'b1;
                o_cmd.idx_raddr = CMD_AW'(r_b + r_j - LW'(1));
                n_state         = S_SI2;
            end
            S_SI2: begin
                o_cmd.ld_tc = 1'b1;
                o_cmd.ld_p  = 1'b1;
                n_state     = S_SI3;
            end
            S_SI3: begin
                o_cmd.idx_we    = 1'b1;
                o_cmd.idx_waddr = CMD_AW'(r_b + r_j);
                if (i_sts.lt) begin
                    // shift the earlier entry up one place
                    o_cmd.idx_wsel = WS_P;
                    n_j            = r_j - LW'(1);
                    if (r_j == LW'(1)) begin
                        n_state = S_SI5;
                    end else begin
                        o_cmd.idx_raddr = CMD_AW'(r_b + r_j - LW'(2));
                        n_state         = S_SI4;
                    end
                end else begin
                    o_cmd.idx_wsel = WS_T;
                    n_i            = r_i + LW'(1);
                    n_state        = ((r_i + LW'(1)) < r_m) ? S_SI0 : S_HS;
                end
            end
            S_SI4: begin
                o_cmd.ld_p = 1'b1;
                n_state    = S_SI3;
            end
            S_SI5: begin
                o_cmd.idx_we    = 1'b1;
                o_cmd.idx_waddr = CMD_AW'(r_b + r_j);
                o_cmd.idx_wsel  = WS_T;
                n_i             = r_i + LW'(1);
                n_state         = ((r_i + LW'(1)) < r_m) ? S_SI0 : S_HS;
            end
            S_HS: begin
                n_s     = LW'(1);
                n_i     = LW'(2);
                n_state = (r_m > LW'(2)) ? S_H0 : S_CE;
            end
            S_H0: begin
                o_cmd.idx_raddr = CMD_AW'(r_b + r_i);
                n_state         = S_H1;
            end
            S_H1: begin
                o_cmd.ld_vi = 1'b1;
                n_j         = r_s;
                n_state     = S_H2;
            end
            S_H2: begin
                o_cmd.ld_ic     = 1'b1;
                o_cmd.idx_raddr = CMD_AW'(r_b + r_j);
                n_state         = S_H3;
            end
            S_H3: begin
                o_cmd.idx_raddr = CMD_AW'(r_b + r_j - LW'(1));
                n_state         = S_H4;
            end
            S_H4: begin
                o_cmd.ld_jc = 1'b1;
                n_state     = S_H5;
            end
            S_H5: begin
                o_cmd.ld_kc = 1'b1;
                n_state     = S_H6;
            end
            S_H6: begin
                o_cmd.ld_diff = 1'b1;
                n_state       = S_H7;
            end
            S_H7: begin
                o_cmd.ld_prod = 1'b1;
                n_state       = S_H8;
            end
            S_H8: begin
                // pop while the turn is not strictly left
                if (i_sts.right && (r_j > LW'(1))) begin
                    n_j             = r_j - LW'(1);
                    o_cmd.idx_raddr = CMD_AW'(r_b + r_j - LW'(1));
                    n_state         = S_H3;
                end else begin
                    if (i_sts.right) begin
                        n_j = '0;
                    end
                    n_state = S_H9;
                end
            end
            S_H9: begin
                n_s             = r_j + LW'(1);
                o_cmd.idx_raddr = CMD_AW'(r_b + r_j + LW'(1));
                n_state         = S_H10;
            end
            S_H10: begin
                o_cmd.ld_p      = 1'b1;
                o_cmd.idx_we    = 1'b1;
                o_cmd.idx_waddr = CMD_AW'(r_b + r_s);
                o_cmd.idx_wsel  = WS_VI;
                n_state         = S_H11;
            end
            S_H11: begin
                o_cmd.idx_we    = 1'b1;
                o_cmd.idx_waddr = CMD_AW'(r_b + r_i);
                o_cmd.idx_wsel  = WS_P;
                n_i             = r_i + LW'(1);
                n_state         = ((r_i + LW'(1)) < r_m) ? S_H0 : S_CE;
            end
            S_CE: begin
                if (!r_rev) begin
                    n_u     = r_s;
                    n_state = S_C0;
                end else begin
                    n_h     = r_u + r_s;
                    n_k     = '0;
                    n_state = S_O0;
                end
            end
            S_C0: begin
                o_cmd.idx_raddr = '0;
                n_state         = S_C1;
            end
            S_C1: begin
                // wrap the first sorted point to the end for the upper chain
                o_cmd.idx_we    = 1'b1;
                o_cmd.idx_waddr = CMD_AW'(r_cnt);
                o_cmd.idx_wsel  = WS_RD;
                n_b             = r_u;
                n_m             = LW'(r_cnt) - r_u + LW'(1);
                n_rev           = 1'b1;
                n_state         = S_CS;
            end
            S_O0: begin
                o_cmd.idx_raddr = CMD_AW'(r_k);
                n_state         = S_O1;
            end
            S_O1: begin
                n_state = S_O2;
            end
            S_O2: begin
                o_cmd.ld_out = 1'b1;
                n_ovalid     = 1'b1;
                n_state      = S_O3;
            end
            S_O3: begin
                if (i_out_ready) begin
                    n_ovalid = 1'b0;
                    n_k      = r_k + LW'(1);
                    if ((r_k + LW'(1)) == r_h) begin
                        n_cnt   = '0;
                        n_drop  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_O0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
            r_rev    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_drop   <= n_drop;
            r_ovalid <= n_ovalid;
            r_rev    <= n_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_j <= n_j; r_s <= n_s; r_b <= n_b; r_m <= n_m;
        r_u <= n_u; r_h <= n_h; r_k <= n_k;
    end

    `CH_ASSERT(a_cnt_range, LW'(r_cnt) <= LW'(MAX_POINTS), "point count past capacity")
    `CH_ASSERT(a_valid_state, !r_ovalid || (r_state == S_O3), "output beat outside output wait")
    `CH_ASSERT(a_no_load_busy, !(o_in_ready && r_ovalid), "loading while a vertex is pending")
    `CH_ASSERT_NEXT(a_last_starts, in_acc && i_in_last, r_state == S_CS, "last beat did not start")
endmodule
